// File: rtl/core/pvm_pkg.sv
// Shared types and constants of the pack voltage monitor.
`timescale 1ns / 1ps
`default_nettype none

package pvm_pkg;

    // Field and register widths
    localparam int SAMPLE_W  = 12;
    localparam int SUM_W     = 22;
    localparam int COUNT_W   = 11;
    localparam int GAIN_W    = 20;
    localparam int OFFSET_W  = 16;
    localparam int THRESH_W  = 20;
    localparam int MV_W      = 21;
    localparam int STATUS_W  = 2;
    localparam int STREAK_W  = 8;
    localparam int HALF_W    = 11;                // sum is multiplied in two halves
    localparam int MULP_W    = GAIN_W + HALF_W;   // one partial product
    localparam int PROD_W    = GAIN_W + SUM_W;    // full product
    localparam int FRAC_W    = 12;                // Q8.12 fraction bits
    localparam int QUO_W     = PROD_W - FRAC_W;   // dividend / quotient width
    localparam int REM_W     = COUNT_W;
    localparam int STEP_W    = 5;

    localparam int MAX_WINDOW = 1024;
    localparam int DIV_STEPS  = QUO_W;

    // Scaled value is clipped here before the offset is added
    localparam logic [QUO_W-1:0] QUO_SAT = QUO_W'(1048575 + 32768);
    localparam logic signed [MV_W-1:0] MV_MAX = {1'b0, {(MV_W-1){1'b1}}};
    localparam logic signed [MV_W-1:0] MV_MIN = {1'b1, {(MV_W-1){1'b0}}};

    localparam logic [STREAK_W-1:0] STREAK_MAX         = 8'd255;
    localparam logic [STREAK_W-1:0] CONNECT_CONFIRM    = 8'd2;
    localparam logic [STREAK_W-1:0] DISCONNECT_CONFIRM = 8'd3;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_SIZE   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_VOLTAGE_GAIN  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_OFFSET_MV     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_DISCONNECT_MV = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_LOW_MV        = 3'd4;

    // Pack status codes
    localparam logic [STATUS_W-1:0] STATUS_DISCONNECTED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NORMAL       = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_LOW          = 2'd2;

    // Stream widths
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_DIV_LOAD,
        ST_DIV,
        ST_POST
    } pvm_state_t;

    // Controller to datapath
    typedef struct packed {
        logic acc;       // sample item taken
        logic mul_lo;    // low half product
        logic mul_hi;    // high half product, accumulate
        logic div_load;  // load dividend
        logic div_step;  // one restoring division step
        logic post;      // finish window, update presence, load output
    } pvm_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic win_done;  // current sample closes the window
        logic out_free;  // output register can take a result
    } pvm_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/pvm_ctrl.sv
// Sequencer of the pack voltage monitor: accumulate, multiply, divide, finish.
`timescale 1ns / 1ps
`default_nettype none

module pvm_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  pvm_pkg::pvm_stat_t     stat,
    output pvm_pkg::pvm_cmd_t      cmd
);
    import pvm_pkg::*;

    pvm_state_t        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    // State and step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && stat.win_done) state_next = ST_MUL_LO;
            end
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = ST_DIV_LOAD;
            ST_DIV_LOAD: begin
                state_next = ST_DIV;
                step_next  = '0;
            end
            ST_DIV: begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1)) state_next = ST_POST;
            end
            ST_POST: begin
                if (stat.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.acc  = s_tvalid;
            end
            ST_MUL_LO:   cmd.mul_lo   = 1'b1;
            ST_MUL_HI:   cmd.mul_hi   = 1'b1;
            ST_DIV_LOAD: cmd.div_load = 1'b1;
            ST_DIV:      cmd.div_step = 1'b1;
            ST_POST:     cmd.post     = stat.out_free;
            default:     cmd          = '0;
        endcase
    end

`ifndef ASSERT_OFF
    // Division never runs past its last step
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> step_reg <= STEP_W'(DIV_STEPS - 1))
        else $error("division step counter overran");

    // A window result is finished only once per division
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.post |=> state_reg == ST_IDLE && !cmd.post)
        else $error("window finished twice");
`endif

endmodule

`default_nettype wire

// File: rtl/core/pvm_datapath.sv
// Datapath: registers, sample accumulator, shared multiplier, divider, presence logic.
`timescale 1ns / 1ps
`default_nettype none

module pvm_datapath (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [pvm_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  wire logic [pvm_pkg::THRESH_W-1:0]        cfg_wdata,
    input  wire logic [pvm_pkg::SAMPLE_W-1:0]        sample_mv,
    input  pvm_pkg::pvm_cmd_t                        cmd,
    output pvm_pkg::pvm_stat_t                       stat,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [pvm_pkg::MV_W-1:0]          pack_mv,
    output logic [pvm_pkg::STATUS_W-1:0]             pack_status
);
    import pvm_pkg::*;

    // Configuration
    logic [COUNT_W-1:0]         window_size_reg;
    logic [GAIN_W-1:0]          gain_reg;
    logic signed [OFFSET_W-1:0] offset_reg;
    logic [THRESH_W-1:0]        disc_reg;
    logic [THRESH_W-1:0]        low_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_size_reg <= COUNT_W'(1);
            gain_reg        <= GAIN_W'(4096);
            offset_reg      <= '0;
            disc_reg        <= '0;
            low_reg         <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_WINDOW_SIZE:   window_size_reg <= cfg_wdata[COUNT_W-1:0];
                REG_VOLTAGE_GAIN:  gain_reg        <= cfg_wdata[GAIN_W-1:0];
                REG_OFFSET_MV:     offset_reg      <= cfg_wdata[OFFSET_W-1:0];
                REG_DISCONNECT_MV: disc_reg        <= cfg_wdata;
                REG_LOW_MV:        low_reg         <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Window accumulator and presence state
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [STREAK_W-1:0] pstreak_reg, pstreak_next;
    logic [STREAK_W-1:0] astreak_reg, astreak_next;
    logic                present_reg, present_next;
    logic                out_valid_reg, out_valid_next;
    // Working registers
    logic [SUM_W-1:0]    msum_reg, msum_next;
    logic [COUNT_W-1:0]  divisor_reg, divisor_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [QUO_W-1:0]    quo_reg, quo_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic signed [MV_W-1:0]  mv_reg, mv_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg       <= '0;
            count_reg     <= '0;
            pstreak_reg   <= '0;
            astreak_reg   <= '0;
            present_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            pstreak_reg   <= pstreak_next;
            astreak_reg   <= astreak_next;
            present_reg   <= present_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        msum_reg    <= msum_next;
        divisor_reg <= divisor_next;
        prod_reg    <= prod_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        mv_reg      <= mv_next;
        status_reg  <= status_next;
    end

    // Effective window length and end-of-window test
    logic [COUNT_W-1:0] win;
    logic [COUNT_W:0]   count_inc;
    logic [SUM_W-1:0]   sum_inc;

    always_comb begin
        priority if (window_size_reg == '0)
            win = COUNT_W'(1);
        else if (window_size_reg > COUNT_W'(MAX_WINDOW))
            win = COUNT_W'(MAX_WINDOW);
        else
            win = window_size_reg;
    end

    assign count_inc = {1'b0, count_reg} + 1'b1;
    assign sum_inc   = sum_reg + SUM_W'(sample_mv);

    // Shared 20x11 multiplier, one half of the sum per cycle
    logic [HALF_W-1:0] mul_b;
    logic [MULP_W-1:0] mul_p;

    assign mul_b = cmd.mul_hi ? msum_reg[SUM_W-1:HALF_W] : msum_reg[HALF_W-1:0];
    assign mul_p = MULP_W'(gain_reg) * MULP_W'(mul_b);

    // Restoring division step
    logic [REM_W:0] trial;
    logic           trial_ge;
    logic [REM_W:0] trial_sub;

    assign trial     = {rem_reg, quo_reg[QUO_W-1]};
    assign trial_ge  = trial >= {1'b0, divisor_reg};
    assign trial_sub = trial - {1'b0, divisor_reg};

    // Scale, offset, saturation and threshold compare
    logic [MV_W-1:0]          quo_sat;
    logic signed [MV_W+1:0]   v_wide;
    logic signed [MV_W-1:0]   v_mv;
    logic                     connected;

    always_comb begin
        quo_sat = (quo_reg > QUO_SAT) ? QUO_SAT[MV_W-1:0] : quo_reg[MV_W-1:0];
        v_wide  = $signed({2'b00, quo_sat})
                + $signed({{(MV_W+2-OFFSET_W){offset_reg[OFFSET_W-1]}}, offset_reg});
        priority if (v_wide > $signed({{2{MV_MAX[MV_W-1]}}, MV_MAX}))
            v_mv = MV_MAX;
        else if (v_wide < $signed({{2{MV_MIN[MV_W-1]}}, MV_MIN}))
            v_mv = MV_MIN;
        else
            v_mv = v_wide[MV_W-1:0];
        connected = $signed({v_mv[MV_W-1], v_mv}) >= $signed({2'b00, disc_reg});
    end

    // Next values
    always_comb begin
        sum_next       = sum_reg;
        count_next     = count_reg;
        pstreak_next   = pstreak_reg;
        astreak_next   = astreak_reg;
        present_next   = present_reg;
        msum_next      = msum_reg;
        divisor_next   = divisor_reg;
        prod_next      = prod_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        mv_next        = mv_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (cmd.acc) begin
            if (count_inc >= {1'b0, win}) begin
                msum_next    = sum_inc;
                divisor_next = count_inc[COUNT_W-1:0];
                sum_next     = '0;
                count_next   = '0;
            end else begin
                sum_next   = sum_inc;
                count_next = count_inc[COUNT_W-1:0];
            end
        end

        if (cmd.mul_lo) prod_next = PROD_W'(mul_p);
        if (cmd.mul_hi) prod_next = prod_reg + {mul_p, {HALF_W{1'b0}}};

        if (cmd.div_load) begin
            quo_next = prod_reg[PROD_W-1:FRAC_W];
            rem_next = '0;
        end
        if (cmd.div_step) begin
            quo_next = {quo_reg[QUO_W-2:0], trial_ge};
            rem_next = trial_ge ? trial_sub[REM_W-1:0] : trial[REM_W-1:0];
        end

        // Streaks, debounced presence and the result item
        if (cmd.post) begin
            if (connected) begin
                pstreak_next = (pstreak_reg == STREAK_MAX) ? pstreak_reg
                                                           : pstreak_reg + 1'b1;
                astreak_next = '0;
            end else begin
                astreak_next = (astreak_reg == STREAK_MAX) ? astreak_reg
                                                           : astreak_reg + 1'b1;
                pstreak_next = '0;
            end
            if (!present_reg) present_next = pstreak_next >= CONNECT_CONFIRM;
            else              present_next = astreak_next < DISCONNECT_CONFIRM;

            if (present_next) begin
                mv_next     = v_mv;
                status_next = ($signed({v_mv[MV_W-1], v_mv}) < $signed({2'b00, low_reg}))
                              ? STATUS_LOW : STATUS_NORMAL;
            end else begin
                mv_next     = '0;
                status_next = STATUS_DISCONNECTED;
            end
            out_valid_next = 1'b1;
        end
    end

    assign stat.win_done = count_inc >= {1'b0, win};
    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign pack_mv       = mv_reg;
    assign pack_status   = status_reg;

`ifndef ASSERT_OFF
    // Only one streak counter runs at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        pstreak_reg != '0 |-> astreak_reg == '0)
        else $error("both streak counters non-zero");

    // A disconnected result carries zero voltage
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && status_reg == STATUS_DISCONNECTED |-> mv_reg == '0)
        else $error("disconnected result with non-zero voltage");

    // Partial window never reaches the longest window
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg < COUNT_W'(MAX_WINDOW))
        else $error("sample count overran window");

    // A result only replaces a taken or empty output
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.post |-> !out_valid_reg || out_ready)
        else $error("result overwritten before it was taken");
`endif

endmodule

`default_nettype wire

// File: rtl/core/pack_voltage_monitor.sv
// Top level of the pack voltage monitor: controller plus datapath.
//
// Usage: ADC samples in millivolts arrive on the s_ stream, one item per
// s_tvalid/s_tready handshake. Samples are summed over a window of
// window_size items (0 acts as 1, values above 1024 act as 1024). The item
// that closes a window produces one result item on the m_ stream: the scaled,
// offset and saturated voltage and a status of disconnected, normal or low,
// with presence debounced over 2 connected / 3 disconnected windows.
// Items inside a window are accepted back to back. The closing item starts a
// split low/high multiply on one 20x11 multiplier, a dividend load, a
// bit-serial restoring divide and a finishing step; s_tready stays low until
// the finishing step is done, so no sample is taken while a result is built.
// The result sits in an output register; if the receiver stalls, a new
// window can still be gathered, and the block waits in its finishing step
// until the pending result is taken. Configuration is written through
// cfg_we/cfg_addr/cfg_wdata; the user must write it only while idle, which
// the block itself does not enforce. Reset clears the accumulator, streaks
// and presence, and restores the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module pack_voltage_monitor (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // s_tdata: [11:0] sample_mv, [15:12] zero
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [pvm_pkg::S_TDATA_W-1:0]    s_tdata,
    // m_tdata: [20:0] pack_mv, [22:21] pack_status, [23] zero
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [pvm_pkg::M_TDATA_W-1:0]         m_tdata,
    input  wire logic                             cfg_we,
    input  wire logic [pvm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [pvm_pkg::THRESH_W-1:0]     cfg_wdata
);
    import pvm_pkg::*;

    pvm_cmd_t                cmd;
    pvm_stat_t               stat;
    logic signed [MV_W-1:0]  pack_mv;
    logic [STATUS_W-1:0]     pack_status;

    pvm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pvm_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .sample_mv   (s_tdata[SAMPLE_W-1:0]),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .pack_mv     (pack_mv),
        .pack_status (pack_status)
    );

    assign m_tdata = {{(M_TDATA_W-MV_W-STATUS_W){1'b0}}, pack_status, pack_mv};

endmodule

`default_nettype wire

// File: dv/pack_voltage_monitor_tb.sv
// Self-checking testbench of the pack voltage monitor: windowed averaging and presence debounce.
`timescale 1ns / 1ps

module pack_voltage_monitor_tb;

    import pvm_pkg::*;

    localparam int SETTLE_CYCLES = 40;          // covers the scale and divide
    localparam int PHASE_ITEMS   = 60;
    localparam int RUN_LIMIT_NS  = 10_000_000;

    // One expected result item
    typedef struct packed {
        logic signed [MV_W-1:0]  mv;
        logic [STATUS_W-1:0]     status;
    } reading_t;

    // Tracks configuration and window state, predicts each window's reading
    class window_scoreboard;
        logic [COUNT_W-1:0]         win_size;
        logic [GAIN_W-1:0]          gain;
        logic signed [OFFSET_W-1:0] offset;
        logic [THRESH_W-1:0]        disc_mv;
        logic [THRESH_W-1:0]        low_mv;
        logic [SUM_W-1:0]           acc_sum;
        logic [COUNT_W-1:0]         acc_count;
        logic [STREAK_W-1:0]        on_streak;
        logic [STREAK_W-1:0]        off_streak;
        bit                         present;
        reading_t                   readings_due[$];
        int                         errors;

        function new();
            win_size   = COUNT_W'(1);
            gain       = GAIN_W'(4096);
            offset     = '0;
            disc_mv    = '0;
            low_mv     = '0;
            acc_sum    = '0;
            acc_count  = '0;
            on_streak  = '0;
            off_streak = '0;
            present    = 1'b0;
            errors     = 0;
        endfunction

        // Register write; indexes past the list are dropped
        function void set_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [THRESH_W-1:0] val);
            case (idx)
                REG_WINDOW_SIZE:   win_size = val[COUNT_W-1:0];
                REG_VOLTAGE_GAIN:  gain     = val[GAIN_W-1:0];
                REG_OFFSET_MV:     offset   = val[OFFSET_W-1:0];
                REG_DISCONNECT_MV: disc_mv  = val;
                REG_LOW_MV:        low_mv   = val;
                default: ;
            endcase
        endfunction

        // Accepted sample: accumulate, and on a closed window queue the reading
        function void take_sample(input logic [SAMPLE_W-1:0] mv);
            logic [COUNT_W-1:0] win;
            longint unsigned    prod;
            longint unsigned    quo;
            longint             v;
            reading_t           r;
            win = (win_size == '0) ? COUNT_W'(1) :
                  ((win_size > MAX_WINDOW) ? COUNT_W'(MAX_WINDOW) : win_size);
            acc_sum   = acc_sum + SUM_W'(mv);
            acc_count = acc_count + COUNT_W'(1);
            if (acc_count < win)
                return;

            // floor(gain * sum / (count * 4096)), clipped, offset, clipped again
            prod = 64'(gain) * 64'(acc_sum);
            quo  = prod / (64'(acc_count) << FRAC_W);
            if (quo > 64'(QUO_SAT))
                quo = 64'(QUO_SAT);
            v = longint'(quo) + longint'(offset);
            if (v > longint'(MV_MAX))
                v = longint'(MV_MAX);
            if (v < longint'(MV_MIN))
                v = longint'(MV_MIN);
            acc_sum   = '0;
            acc_count = '0;

            // streaks saturate, each clears the other
            if (v >= longint'(disc_mv)) begin
                if (on_streak != STREAK_MAX)
                    on_streak++;
                off_streak = '0;
            end else begin
                if (off_streak != STREAK_MAX)
                    off_streak++;
                on_streak = '0;
            end
            if (!present && on_streak >= CONNECT_CONFIRM)
                present = 1'b1;
            else if (present && off_streak >= DISCONNECT_CONFIRM)
                present = 1'b0;

            if (present) begin
                r.mv     = MV_W'(v);
                r.status = (v < longint'(low_mv)) ? STATUS_LOW : STATUS_NORMAL;
            end else begin
                r.mv     = '0;
                r.status = STATUS_DISCONNECTED;
            end
            readings_due.push_back(r);
        endfunction

        // Result item against the oldest expected reading
        function void check_reading(input logic [M_TDATA_W-1:0] tdata);
            reading_t want;
            if (readings_due.size() == 0) begin
                $display("%0t: unexpected item, expected none, got %h", $time, tdata);
                errors++;
                return;
            end
            want = readings_due.pop_front();
            if (tdata[MV_W-1:0] !== want.mv) begin
                $display("%0t: pack_mv expected %0d, got %0d", $time,
                         $signed(want.mv), $signed(tdata[MV_W-1:0]));
                errors++;
            end
            if (tdata[MV_W +: STATUS_W] !== want.status) begin
                $display("%0t: pack_status expected %0d, got %0d", $time,
                         want.status, tdata[MV_W +: STATUS_W]);
                errors++;
            end
            if (tdata[M_TDATA_W-1:MV_W+STATUS_W] !== '0) begin
                $display("%0t: tdata padding expected 0, got %b", $time,
                         tdata[M_TDATA_W-1:MV_W+STATUS_W]);
                errors++;
            end
        endfunction
    endclass

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
    logic [THRESH_W-1:0]    cfg_wdata = '0;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;

    window_scoreboard sb = new();

    pack_voltage_monitor DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic bit chance(input int pct);
        return $urandom_range(99, 0) < pct;
    endfunction

    // Result side: check taken items, stall at random
    always @(posedge aclk) begin
        if (m_tvalid && m_tready)
            sb.check_reading(m_tdata);
        m_tready <= aresetn && !chance(sink_stall_pct);
    end

    // One sample item, with an optional idle gap before it
    task automatic send_sample(input logic [SAMPLE_W-1:0] mv);
        if (chance(src_idle_pct)) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while (chance(src_idle_pct))
                @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(mv);
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.take_sample(mv);
    endtask

    // Hold the sender off until every reading is in and the block is quiet
    task automatic wait_for_readings();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.readings_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Leaves cfg_we high; the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [THRESH_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.set_reg(idx, val);
    endtask

    // Full register set, plus a write to an unused index; unused upper bits random
    task automatic program_regs(input logic [COUNT_W-1:0] win, input logic [GAIN_W-1:0] gain,
                                input logic [OFFSET_W-1:0] off,
                                input logic [THRESH_W-1:0] disc,
                                input logic [THRESH_W-1:0] lowv);
        write_reg(REG_WINDOW_SIZE, {(THRESH_W-COUNT_W)'($urandom), win});
        write_reg(REG_VOLTAGE_GAIN, gain);
        write_reg(REG_OFFSET_MV, {(THRESH_W-OFFSET_W)'($urandom), off});
        write_reg(REG_DISCONNECT_MV, disc);
        write_reg(REG_LOW_MV, lowv);
        write_reg(CFG_ADDR_W'($urandom_range(2**CFG_ADDR_W - 1, REG_LOW_MV + 1)),
                  THRESH_W'($urandom));
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        int                   ph;
        int                   sent;
        int                   burst;
        int                   level;
        int                   val;
        logic [COUNT_W-1:0]   win;
        logic [GAIN_W-1:0]    gain;
        logic [OFFSET_W-1:0]  off;
        logic [THRESH_W-1:0]  disc;
        logic [THRESH_W-1:0]  lowv;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: zero reading still counts as connected
        send_sample(SAMPLE_W'(0));
        send_sample(SAMPLE_W'(4095));
        send_sample(SAMPLE_W'(2048));
        wait_for_readings();

        // Window of zero, gain zero, lowest offset: negative low readings, then drop-out
        program_regs('0, '0, 16'h8000, '0, '0);
        repeat (3) send_sample(SAMPLE_W'($urandom));
        wait_for_readings();

        // Top gain and offset saturate; window shrunk from 8 to 3 mid-window
        program_regs(COUNT_W'(8), '1, 16'h7FFF, '1, '1);
        repeat (5) send_sample(SAMPLE_W'(4095));
        wait_for_readings();
        program_regs(COUNT_W'(3), '1, 16'h7FFF, '1, '1);
        repeat (4) send_sample(SAMPLE_W'(4095));
        wait_for_readings();

        // Normal, low, and the three-window disconnect
        program_regs(COUNT_W'(1), GAIN_W'(4096), '0, THRESH_W'(100), THRESH_W'(3000));
        send_sample(SAMPLE_W'(4000));
        send_sample(SAMPLE_W'(1000));
        repeat (3) send_sample(SAMPLE_W'(50));
        wait_for_readings();

        // Random phases over the four idling patterns
        for (ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 76; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 76; end
                default: begin src_idle_pct = 21; sink_stall_pct = 21; end
            endcase

            case ($urandom_range(9, 0))
                0:       win = '0;
                1, 2:    win = COUNT_W'(1);
                3:       win = COUNT_W'($urandom_range(16, 7));
                default: win = COUNT_W'($urandom_range(6, 2));
            endcase
            case ($urandom_range(9, 0))
                0:       gain = '0;
                1:       gain = '1;
                2:       gain = GAIN_W'($urandom);
                default: gain = GAIN_W'($urandom_range(12288, 2048));
            endcase
            case ($urandom_range(9, 0))
                0:       off = 16'h8000;
                1:       off = 16'h7FFF;
                2:       off = OFFSET_W'($urandom);
                default: off = OFFSET_W'($urandom_range(4000, 0)) - OFFSET_W'(2000);
            endcase
            disc = chance(10) ? THRESH_W'($urandom) : THRESH_W'($urandom_range(5000, 0));
            lowv = chance(10) ? '1 : THRESH_W'($urandom_range(6000, 0));
            program_regs(win, gain, off, disc, lowv);

            // Bursts around one level so whole windows land high or low
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                level = $urandom_range(4095, 0);
                burst = $urandom_range(12, 1);
                repeat (burst) begin
                    if (chance(5))
                        val = 0;
                    else if (chance(5))
                        val = 4095;
                    else if (chance(10))
                        val = $urandom_range(4095, 0);
                    else begin
                        val = level + $urandom_range(128, 0) - 64;
                        if (val < 0)
                            val = 0;
                        if (val > 4095)
                            val = 4095;
                    end
                    send_sample(SAMPLE_W'(val));
                    sent++;
                    if (sent == PHASE_ITEMS / 2)
                        wait_for_readings();
                end
            end
            wait_for_readings();
        end

        // Oversized window register: no early close, then a shrink ends the long window
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        program_regs('1, '1, OFFSET_W'($urandom), THRESH_W'($urandom), THRESH_W'($urandom));
        repeat (20) send_sample(SAMPLE_W'(4095));
        wait_for_readings();
        program_regs(COUNT_W'(2), '1, OFFSET_W'($urandom), THRESH_W'($urandom),
                     THRESH_W'($urandom));
        send_sample(SAMPLE_W'(4095));
        wait_for_readings();

        if (sb.errors == 0 && sb.readings_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Run limit
    initial begin
        #(RUN_LIMIT_NS);
        $display("tb: failure");
        $finish;
    end

endmodule
